// ===== rtl/msa_tone_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package msa_tone_pkg;

	// Sensor scan geometry
	localparam int SENSOR_COUNT      = 4;
	localparam int SENSOR_W          = $clog2(SENSOR_COUNT);
	localparam int TEMP_SENSOR_INDEX = 0;
	localparam int SAMPLE_W          = 16;

	// Threshold registers
	localparam int THR_COUNT = 8;
	localparam int THR_IDX_W = $clog2(THR_COUNT);

	// Tone arithmetic
	localparam int CAUTION_SPAN_HZ = 500;
	localparam int ALT_SPAN_HZ     = 30;
	localparam int ALT_BASE_HZ     = 5;
	localparam int SCALE_MAX       = (CAUTION_SPAN_HZ > ALT_SPAN_HZ) ?
	                                 CAUTION_SPAN_HZ : ALT_SPAN_HZ;
	localparam int SCALE_W         = $clog2(SCALE_MAX + 1);
	// magnitude of scale * |sample - origin|
	localparam int NUM_W           = $clog2(SCALE_MAX * (2 ** SAMPLE_W));
	localparam int DIV_CNT_W       = $clog2(NUM_W);

	typedef logic [SAMPLE_W-1:0] sample_t;

	localparam sample_t FREQ_MAX = 16'hFFFF;

	localparam sample_t THR_RESET [THR_COUNT] = '{
		16'd11800, 16'd13433, 16'd25234, 16'd26867,
		16'd38668, 16'd40301, 16'd52102, 16'd53735
	};

	// Base tone pair per sensor
	localparam sample_t TONE_LO [SENSOR_COUNT] = '{16'd500, 16'd1200, 16'd1850, 16'd2500};
	localparam sample_t TONE_HI [SENSOR_COUNT] = '{16'd1000, 16'd1700, 16'd2250, 16'd3000};

	typedef enum logic [2:0] {
		LVL_NORMAL,
		LVL_ADVISORY,
		LVL_CAUTION,
		LVL_WARNING,
		LVL_EMERGENCY
	} lvl_t;

	typedef enum logic [1:0] {
		MODE_SILENT,
		MODE_STEADY,
		MODE_ALT
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic classify;
		logic mul;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_full;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/multi_sensor_alarm_zone_tone_select_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Four-sensor alarm classifier and tone selector. Each input item is one scan of four
// 16-bit samples; each sample is placed in one of five alarm levels against eight shared
// thresholds (written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce), with hysteresis for
// all sensors but the temperature one. The most severe sensor wins, ties to the lower
// index, and one result item gives its level and tone description. An accepted item
// passes through classify, the multiply, the one-bit-per-cycle serial divider that forms
// the frequency offset, a step to see the divider finish and one to load the result.
// The next item can be accepted the cycle after that, so only one item is in work at a
// time; a result that is not taken holds the block in its last step. The result register
// lets the next item be accepted while the previous result waits to be taken.
module multi_sensor_alarm_zone_tone_select_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [msa_tone_pkg::THR_IDX_W-1:0] cfg_index,
	input  wire msa_tone_pkg::sample_t             cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire msa_tone_pkg::sample_t             sample_a,
	input  wire msa_tone_pkg::sample_t             sample_b,
	input  wire msa_tone_pkg::sample_t             sample_c,
	input  wire msa_tone_pkg::sample_t             sample_d,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [1:0]                             active_sensor,
	output logic [2:0]                             active_level,
	output logic [3:0]                             advisory_mask,
	output logic [1:0]                             tone_mode,
	output msa_tone_pkg::sample_t                  tone_low_hz,
	output msa_tone_pkg::sample_t                  tone_high_hz,
	output msa_tone_pkg::sample_t                  alternate_hz
);
	import msa_tone_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	msa_tone_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	msa_tone_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_a      (sample_a),
		.sample_b      (sample_b),
		.sample_c      (sample_c),
		.sample_d      (sample_d),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.active_sensor (active_sensor),
		.active_level  (active_level),
		.advisory_mask (advisory_mask),
		.tone_mode     (tone_mode),
		.tone_low_hz   (tone_low_hz),
		.tone_high_hz  (tone_high_hz),
		.alternate_hz  (alternate_hz)
	);

	// One item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while another is in work");

	// A result never overwrites one not yet taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid || out_ready))
		else $error("result register overwritten");

	// Divider cannot report done right after a start
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |=> !status.div_done)
		else $error("divider done too early");

	// A silent result carries no tone
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tone_mode == MODE_SILENT) |->
			(tone_low_hz == '0 && tone_high_hz == '0 && alternate_hz == '0))
		else $error("silent result with nonzero tone");

endmodule
`default_nettype wire

// ===== rtl/msa_tone_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msa_tone_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [msa_tone_pkg::NUM_W-1:0] num,
	input  wire msa_tone_pkg::sample_t         den,
	output logic      [msa_tone_pkg::NUM_W-1:0] quo,
	output logic                               done
);
	import msa_tone_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	sample_t              rem_q;
	sample_t              den_q;
	logic [NUM_W-1:0]     quo_q;

	logic [SAMPLE_W:0]    shifted;
	logic [SAMPLE_W+1:0]  trial;

	// Restoring step: bring down one numerator bit, try to subtract
	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		trial   = {1'b0, shifted} - {2'b00, den_q};
	end

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ~trial[SAMPLE_W+1]};
			rem_q <= trial[SAMPLE_W+1] ? shifted[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ===== rtl/msa_tone_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msa_tone_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire msa_tone_pkg::dp_cmd_t             cmd,
	output msa_tone_pkg::dp_status_t               status,
	input  wire logic                              cfg_we,
	input  wire logic [msa_tone_pkg::THR_IDX_W-1:0] cfg_index,
	input  wire msa_tone_pkg::sample_t             cfg_data,
	input  wire msa_tone_pkg::sample_t             sample_a,
	input  wire msa_tone_pkg::sample_t             sample_b,
	input  wire msa_tone_pkg::sample_t             sample_c,
	input  wire msa_tone_pkg::sample_t             sample_d,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic [1:0]                             active_sensor,
	output logic [2:0]                             active_level,
	output logic [3:0]                             advisory_mask,
	output logic [1:0]                             tone_mode,
	output msa_tone_pkg::sample_t                  tone_low_hz,
	output msa_tone_pkg::sample_t                  tone_high_hz,
	output msa_tone_pkg::sample_t                  alternate_hz
);
	import msa_tone_pkg::*;

	sample_t              thr_q [THR_COUNT];
	sample_t              smp_q [SENSOR_COUNT];
	lvl_t                 level_q [SENSOR_COUNT];
	lvl_t                 lvl_sel_q;
	logic [SENSOR_W-1:0]  hi_q;
	logic [SENSOR_COUNT-1:0] mask_q;
	sample_t              s_sel_q;
	logic                 neg_q;
	logic                 den_zero_q;

	logic                 out_valid_q;
	logic [1:0]           active_sensor_q;
	logic [2:0]           active_level_q;
	logic [3:0]           advisory_mask_q;
	logic [1:0]           tone_mode_q;
	sample_t              tone_low_q;
	sample_t              tone_high_q;
	sample_t              alternate_q;

	// Zone classification of one sensor
	function automatic lvl_t classify(input logic [SENSOR_W-1:0] idx, input sample_t s,
	                                  input lvl_t prev);
		lvl_t r;
		if (idx == SENSOR_W'(TEMP_SENSOR_INDEX)) begin
			// symmetric window, no hysteresis
			if (s < thr_q[0] || s > thr_q[7])      r = LVL_EMERGENCY;
			else if (s < thr_q[1] || s > thr_q[6]) r = LVL_WARNING;
			else if (s < thr_q[2] || s > thr_q[5]) r = LVL_CAUTION;
			else if (s < thr_q[3] || s > thr_q[4]) r = LVL_ADVISORY;
			else                                   r = LVL_NORMAL;
		end else begin
			if (s < thr_q[0])      r = LVL_NORMAL;
			else if (s < thr_q[1]) r = prev;
			else if (s < thr_q[2]) r = LVL_ADVISORY;
			else if (s < thr_q[3]) r = prev;
			else if (s < thr_q[4]) r = LVL_CAUTION;
			else if (s < thr_q[5]) r = prev;
			else if (s < thr_q[6]) r = LVL_WARNING;
			else if (s < thr_q[7]) r = prev;
			else                   r = LVL_EMERGENCY;
		end
		return r;
	endfunction

	// Threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THR_COUNT; i++) thr_q[i] <= THR_RESET[i];
		end else if (cfg_we) begin
			thr_q[cfg_index] <= cfg_data;
		end
	end

	// Scan capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smp_q[0] <= sample_a;
			smp_q[1] <= sample_b;
			smp_q[2] <= sample_c;
			smp_q[3] <= sample_d;
		end
	end

	// Classification and most severe sensor
	lvl_t                    lvl_new [SENSOR_COUNT];
	logic [SENSOR_W-1:0]     hi_c;
	logic [SENSOR_COUNT-1:0] mask_c;

	always_comb begin
		hi_c   = '0;
		mask_c = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			lvl_new[i] = classify(SENSOR_W'(i), smp_q[i], level_q[i]);
			mask_c[i]  = (lvl_new[i] == LVL_ADVISORY);
		end
		for (int i = 1; i < SENSOR_COUNT; i++) begin
			if (lvl_new[i] > lvl_new[hi_c]) hi_c = SENSOR_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENSOR_COUNT; i++) level_q[i] <= LVL_NORMAL;
		end else if (cmd.classify) begin
			for (int i = 0; i < SENSOR_COUNT; i++) level_q[i] <= lvl_new[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			hi_q      <= hi_c;
			lvl_sel_q <= lvl_new[hi_c];
			mask_q    <= mask_c;
			s_sel_q   <= smp_q[hi_c];
		end
	end

	// Offset numerator and divisor for the selected level
	sample_t               origin;
	sample_t               span_end;
	logic [SAMPLE_W:0]     diff;
	logic [SAMPLE_W:0]     diff_n;
	logic [SAMPLE_W:0]     dspan;
	logic [SAMPLE_W:0]     dspan_n;
	sample_t               diff_mag;
	sample_t               den_mag;
	logic [SCALE_W-1:0]    scale;
	logic [NUM_W-1:0]      prod;

	always_comb begin
		unique case (lvl_sel_q)
			LVL_WARNING: begin
				origin   = thr_q[5];
				span_end = thr_q[6];
			end
			LVL_EMERGENCY: begin
				origin   = thr_q[7];
				span_end = FREQ_MAX;
			end
			default: begin
				origin   = thr_q[3];
				span_end = thr_q[4];
			end
		endcase
		scale    = (lvl_sel_q == LVL_CAUTION) ? SCALE_W'(CAUTION_SPAN_HZ) :
		                                        SCALE_W'(ALT_SPAN_HZ);
		diff     = {1'b0, s_sel_q} - {1'b0, origin};
		diff_n   = -diff;
		dspan    = {1'b0, span_end} - {1'b0, origin};
		dspan_n  = -dspan;
		diff_mag = diff[SAMPLE_W] ? diff_n[SAMPLE_W-1:0] : diff[SAMPLE_W-1:0];
		den_mag  = dspan[SAMPLE_W] ? dspan_n[SAMPLE_W-1:0] : dspan[SAMPLE_W-1:0];
		prod     = NUM_W'(scale) * NUM_W'(diff_mag);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			neg_q      <= diff[SAMPLE_W] ^ dspan[SAMPLE_W];
			den_zero_q <= (dspan == '0);
		end
	end

	// Serial divider, product registered at its input
	logic [NUM_W-1:0] quo;
	logic             div_done;

	msa_tone_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul),
		.num    (prod),
		.den    (den_mag),
		.quo    (quo),
		.done   (div_done)
	);

	// Signed offset plus base, saturated
	logic signed [NUM_W+1:0] off_s;
	logic signed [NUM_W+1:0] sum_s;
	sample_t                 base;
	sample_t                 freq;

	always_comb begin
		base = (lvl_sel_q == LVL_CAUTION) ? TONE_LO[hi_q] : SAMPLE_W'(ALT_BASE_HZ);
		if (den_zero_q)
			off_s = '0;
		else if (neg_q)
			off_s = -$signed({2'b00, quo});
		else
			off_s = $signed({2'b00, quo});
		sum_s = off_s + $signed({{(NUM_W+2-SAMPLE_W){1'b0}}, base});
		if (sum_s[NUM_W+1])
			freq = '0;
		else if (|sum_s[NUM_W:SAMPLE_W])
			freq = FREQ_MAX;
		else
			freq = sum_s[SAMPLE_W-1:0];
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			active_sensor_q <= hi_q;
			active_level_q  <= lvl_sel_q;
			advisory_mask_q <= mask_q;
			unique case (lvl_sel_q)
				LVL_CAUTION: begin
					tone_mode_q <= MODE_STEADY;
					tone_low_q  <= freq;
					tone_high_q <= '0;
					alternate_q <= '0;
				end
				LVL_WARNING: begin
					tone_mode_q <= MODE_ALT;
					tone_low_q  <= TONE_LO[hi_q];
					tone_high_q <= TONE_HI[hi_q];
					alternate_q <= freq;
				end
				LVL_EMERGENCY: begin
					tone_mode_q <= MODE_ALT;
					tone_low_q  <= '0;
					tone_high_q <= TONE_HI[hi_q];
					alternate_q <= freq;
				end
				default: begin
					tone_mode_q <= MODE_SILENT;
					tone_low_q  <= '0;
					tone_high_q <= '0;
					alternate_q <= '0;
				end
			endcase
		end
	end

	assign status.div_done = div_done;
	assign status.out_full = out_valid_q;

	assign out_valid     = out_valid_q;
	assign active_sensor = active_sensor_q;
	assign active_level  = active_level_q;
	assign advisory_mask = advisory_mask_q;
	assign tone_mode     = tone_mode_q;
	assign tone_low_hz   = tone_low_q;
	assign tone_high_hz  = tone_high_q;
	assign alternate_hz  = alternate_q;

endmodule
`default_nettype wire

// ===== rtl/msa_tone_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msa_tone_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     out_ready,
	input  wire msa_tone_pkg::dp_status_t status,
	output msa_tone_pkg::dp_cmd_t         cmd
);
	import msa_tone_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_free;

	assign out_free = !status.out_full || out_ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_CLASS;
			ST_CLASS: state_nxt = ST_MUL;
			ST_MUL:   state_nxt = ST_DIV;
			ST_DIV:   if (status.div_done) state_nxt = ST_DONE;
			ST_DONE:  if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CLASS: cmd.classify = 1'b1;
			ST_MUL:   cmd.mul = 1'b1;
			ST_DIV:   ;
			ST_DONE:  cmd.finish = out_free;
			default:  ;
		endcase
	end

endmodule
`default_nettype wire

// ===== dv/msa_alarm_checker.sv =====
`timescale 1ns / 1ps
// Watches the scan, alarm and threshold ports of the alarm block, works out the
// alarm item that each accepted scan must produce and compares it field by field.
module msa_alarm_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [msa_tone_pkg::THR_IDX_W-1:0] cfg_index,
	input  msa_tone_pkg::sample_t             cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  msa_tone_pkg::sample_t             sample_a,
	input  msa_tone_pkg::sample_t             sample_b,
	input  msa_tone_pkg::sample_t             sample_c,
	input  msa_tone_pkg::sample_t             sample_d,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [1:0]                        active_sensor,
	input  logic [2:0]                        active_level,
	input  logic [3:0]                        advisory_mask,
	input  logic [1:0]                        tone_mode,
	input  msa_tone_pkg::sample_t             tone_low_hz,
	input  msa_tone_pkg::sample_t             tone_high_hz,
	input  msa_tone_pkg::sample_t             alternate_hz,
	output int                                fail_count,
	output int                                pending,
	output int                                checked,
	output logic [4:0]                        level_hits
);
	import msa_tone_pkg::*;

	// Threshold registers that set the tone origins and spans
	localparam int T_CAU_LO  = 3;
	localparam int T_CAU_HI  = 4;
	localparam int T_WARN_LO = 5;
	localparam int T_WARN_HI = 6;
	localparam int T_EMERG   = 7;

	typedef struct packed {
		logic [1:0] sensor;
		lvl_t       level;
		logic [3:0] adv;
		mode_t      mode;
		sample_t    lo;
		sample_t    hi;
		sample_t    alt;
	} alarm_t;

	sample_t    thr [THR_COUNT];
	lvl_t       zone_mem [SENSOR_COUNT];
	alarm_t     alarm_q [$];
	alarm_t     want;
	int         mismatches;
	int         checked_n;
	logic [4:0] hits;

	// Level of one sensor; non-temperature sensors hold their level in the odd bands
	function automatic lvl_t zone_of(input int idx, input sample_t s, input lvl_t prev);
		if (idx == TEMP_SENSOR_INDEX) begin
			// symmetric window, outermost threshold pair first
			for (int k = 0; k < THR_COUNT / 2; k++)
				if (s < thr[k] || s > thr[THR_COUNT-1-k])
					return lvl_t'(LVL_EMERGENCY - k);
			return LVL_NORMAL;
		end
		for (int k = 0; k < THR_COUNT; k++)
			if (s < thr[k])
				return (k % 2 == 1) ? prev : lvl_t'(k / 2);
		return LVL_EMERGENCY;
	endfunction

	// base + gain*(s-origin)/(end-origin), signed, truncating, clamped to 16 bits
	function automatic sample_t tone_scale(input longint base_hz, input longint gain,
			input sample_t s, input longint origin, input longint span_end);
		longint den;
		longint off;
		longint hz;
		longint sl;
		sl  = s;
		den = span_end - origin;
		off = 0;
		if (den != 0)
			off = (gain * (sl - origin)) / den;
		hz = base_hz + off;
		if (hz < 0)
			hz = 0;
		if (hz > longint'(FREQ_MAX))
			hz = longint'(FREQ_MAX);
		return sample_t'(hz);
	endfunction

	// Alarm item for one scan; advances the stored levels
	function automatic alarm_t alarm_of_scan(input sample_t a, input sample_t b,
			input sample_t c, input sample_t d);
		alarm_t  r;
		sample_t s [SENSOR_COUNT];
		int      top_i;
		s[0] = a;
		s[1] = b;
		s[2] = c;
		s[3] = d;
		r = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			zone_mem[i] = zone_of(i, s[i], zone_mem[i]);
			if (zone_mem[i] == LVL_ADVISORY)
				r.adv[i] = 1'b1;
		end
		// ties stay with the lower index
		top_i = 0;
		for (int i = 1; i < SENSOR_COUNT; i++)
			if (zone_mem[i] > zone_mem[top_i])
				top_i = i;
		r.sensor = 2'(top_i);
		r.level  = zone_mem[top_i];
		r.mode   = MODE_SILENT;
		case (r.level)
			LVL_CAUTION: begin
				r.mode = MODE_STEADY;
				r.lo   = tone_scale(TONE_LO[top_i], CAUTION_SPAN_HZ, s[top_i],
				                    thr[T_CAU_LO], thr[T_CAU_HI]);
			end
			LVL_WARNING: begin
				r.mode = MODE_ALT;
				r.lo   = TONE_LO[top_i];
				r.hi   = TONE_HI[top_i];
				r.alt  = tone_scale(ALT_BASE_HZ, ALT_SPAN_HZ, s[top_i],
				                    thr[T_WARN_LO], thr[T_WARN_HI]);
			end
			LVL_EMERGENCY: begin
				r.mode = MODE_ALT;
				r.hi   = TONE_HI[top_i];
				r.alt  = tone_scale(ALT_BASE_HZ, ALT_SPAN_HZ, s[top_i],
				                    thr[T_EMERG], FREQ_MAX);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, actual %0d", name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Track thresholds, predict on scan accept, compare on alarm accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THR_COUNT; i++)
				thr[i] = THR_RESET[i];
			for (int i = 0; i < SENSOR_COUNT; i++)
				zone_mem[i] = LVL_NORMAL;
			alarm_q.delete();
			mismatches = 0;
			checked_n  = 0;
			hits       = '0;
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
			level_hits <= '0;
		end else begin
			// alarm side first: it pairs with scans taken at earlier edges
			if (out_valid && out_ready) begin
				if (alarm_q.size() == 0) begin
					$error("alarm item with no scan waiting for it");
					mismatches++;
				end else begin
					want = alarm_q.pop_front();
					check_field("active_sensor", want.sensor, active_sensor);
					check_field("active_level", want.level, active_level);
					check_field("advisory_mask", want.adv, advisory_mask);
					check_field("tone_mode", want.mode, tone_mode);
					check_field("tone_low_hz", want.lo, tone_low_hz);
					check_field("tone_high_hz", want.hi, tone_high_hz);
					check_field("alternate_hz", want.alt, alternate_hz);
					checked_n++;
				end
			end
			if (in_valid && in_ready) begin
				want = alarm_of_scan(sample_a, sample_b, sample_c, sample_d);
				hits[want.level] = 1'b1;
				alarm_q.push_back(want);
			end
			if (cfg_we)
				thr[cfg_index] = cfg_data;
			fail_count <= mismatches;
			pending    <= alarm_q.size();
			checked    <= checked_n;
			level_hits <= hits;
		end
	end

endmodule

// ===== dv/tb_multi_sensor_alarm_zone_tone_select_top.sv =====
`timescale 1ns / 1ps
module tb_multi_sensor_alarm_zone_tone_select_top;
	import msa_tone_pkg::*;

	localparam int PHASES          = 10;
	localparam int SCANS_PER_PHASE = 115;
	localparam int SETTLE_CYCLES   = 40;
	localparam int IDLE_MAX        = 17;
	localparam int CYCLE_LIMIT     = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [THR_IDX_W-1:0] cfg_index;
	sample_t              cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	sample_t              sample_a;
	sample_t              sample_b;
	sample_t              sample_c;
	sample_t              sample_d;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           active_sensor;
	logic [2:0]           active_level;
	logic [3:0]           advisory_mask;
	logic [1:0]           tone_mode;
	sample_t              tone_low_hz;
	sample_t              tone_high_hz;
	sample_t              alternate_hz;

	int         fail_count;
	int         pending;
	int         checked;
	logic [4:0] level_hits;

	sample_t thr_shadow [THR_COUNT];
	int      scans_sent   = 0;
	int      alarms_taken = 0;
	int      cycles       = 0;

	multi_sensor_alarm_zone_tone_select_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_a     (sample_a),
		.sample_b     (sample_b),
		.sample_c     (sample_c),
		.sample_d     (sample_d),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.active_sensor(active_sensor),
		.active_level (active_level),
		.advisory_mask(advisory_mask),
		.tone_mode    (tone_mode),
		.tone_low_hz  (tone_low_hz),
		.tone_high_hz (tone_high_hz),
		.alternate_hz (alternate_hz)
	);

	msa_alarm_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_a     (sample_a),
		.sample_b     (sample_b),
		.sample_c     (sample_c),
		.sample_d     (sample_d),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.active_sensor(active_sensor),
		.active_level (active_level),
		.advisory_mask(advisory_mask),
		.tone_mode    (tone_mode),
		.tone_low_hz  (tone_low_hz),
		.tone_high_hz (tone_high_hz),
		.alternate_hz (alternate_hz),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked),
		.level_hits   (level_hits)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL multi_sensor_alarm_zone_tone_select_top");
			$finish;
		end
	end

	// Sample mostly near the thresholds or inside a band so the kept levels get exercised
	function automatic sample_t pick_sample();
		int j;
		int lo;
		int hi;
		int v;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom_range(0, int'(FREQ_MAX));
			2: v = $urandom_range(0, 1) ? int'(FREQ_MAX) : 0;
			3, 4, 5: v = int'(thr_shadow[$urandom_range(0, THR_COUNT-1)]) +
			             int'($urandom_range(0, 6)) - 3;
			default: begin
				j  = $urandom_range(0, THR_COUNT-2);
				lo = thr_shadow[j];
				hi = thr_shadow[j+1];
				if (lo > hi) begin
					lo = thr_shadow[j+1];
					hi = thr_shadow[j];
				end
				v = $urandom_range(lo, hi);
			end
		endcase
		if (v < 0)
			v = 0;
		if (v > int'(FREQ_MAX))
			v = int'(FREQ_MAX);
		return sample_t'(v);
	endfunction

	// Phase thresholds: extremes, zero spans, unordered, tight and mixed spans, reset values
	function automatic void choose_thresholds(input int p);
		int acc;
		int step;
		acc = $urandom_range(0, 12000);
		for (int i = 0; i < THR_COUNT; i++) begin
			case (p)
				1: thr_shadow[i] = '0;
				2: thr_shadow[i] = FREQ_MAX;
				4, 7: thr_shadow[i] = sample_t'($urandom_range(0, int'(FREQ_MAX)));
				9: thr_shadow[i] = THR_RESET[i];
				default: begin
					if (i > 0) begin
						if (p == 3 && i % 2 == 0)
							step = 0;
						else if (p == 5)
							step = $urandom_range(0, 20);
						else
							step = $urandom_range(0, 1) ? $urandom_range(0, 20) :
							                              $urandom_range(0, 15000);
						acc += step;
					end
					if (acc > int'(FREQ_MAX))
						acc = int'(FREQ_MAX);
					thr_shadow[i] = sample_t'(acc);
				end
			endcase
		end
		// zero-width emergency span too
		if (p == 3)
			thr_shadow[THR_COUNT-1] = FREQ_MAX;
	endfunction

	task automatic load_thresholds();
		for (int i = 0; i < THR_COUNT; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= THR_IDX_W'(i);
			cfg_data  <= thr_shadow[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// One scan item; idle stretches without gaps every 64 items
	task automatic send_scan(input sample_t a, input sample_t b, input sample_t c,
			input sample_t d);
		int gap;
		gap = (scans_sent % 64 < 16) ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_a <= a;
		sample_b <= b;
		sample_c <= c;
		sample_d <= d;
		do @(posedge clk); while (!(in_valid && in_ready));
		scans_sent++;
	endtask

	// Wait for every alarm item, then let the block settle
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Directed scans at the reset thresholds
	task automatic run_directed();
		send_scan(16'd0, 16'd0, 16'd0, 16'd0);
		send_scan(16'd65535, 16'd65535, 16'd65535, 16'd65535);
		send_scan(16'd32000, 16'd20000, 16'd30000, 16'd45000);
		send_scan(16'd32000, 16'd38667, 16'd0, 16'd0);
		send_scan(16'd32000, 16'd26867, 16'd0, 16'd0);
		// caution held below its origin: negative offset
		send_scan(16'd32000, 16'd12000, 16'd0, 16'd0);
		send_scan(16'd32000, 16'd0, 16'd0, 16'd0);
		send_scan(16'd32000, 16'd12000, 16'd13432, 16'd0);
		send_scan(16'd32000, 16'd20000, 16'd26000, 16'd25234);
		send_scan(16'd32000, 16'd26000, 16'd20000, 16'd53734);
		send_scan(16'd12000, 16'd40000, 16'd45000, 16'd52101);
		// temperature window, both sides
		send_scan(16'd20000, 16'd0, 16'd0, 16'd0);
		send_scan(16'd26000, 16'd0, 16'd0, 16'd0);
		send_scan(16'd40000, 16'd0, 16'd0, 16'd0);
		send_scan(16'd45000, 16'd0, 16'd0, 16'd0);
		send_scan(16'd53000, 16'd0, 16'd0, 16'd0);
		send_scan(16'd60000, 16'd0, 16'd0, 16'd0);
		// ties go to the lower index
		send_scan(16'd32000, 16'd53735, 16'd53735, 16'd53735);
		send_scan(16'd32000, 16'd40301, 16'd40301, 16'd52101);
		send_scan(16'd32000, 16'd30000, 16'd30000, 16'd30000);
		send_scan(16'd11799, 16'd11800, 16'd13433, 16'd25233);
		send_scan(16'd26867, 16'd38668, 16'd52102, 16'd65535);
	endtask

	// Alarm side: a random stall before each item, with stretches of none
	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = (alarms_taken % 80 < 24) ? 0 : $urandom_range(0, IDLE_MAX);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			alarms_taken++;
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		sample_a  <= '0;
		sample_b  <= '0;
		sample_c  <= '0;
		sample_d  <= '0;
		for (int i = 0; i < THR_COUNT; i++)
			thr_shadow[i] = THR_RESET[i];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				run_directed();
			end else begin
				choose_thresholds(p);
				load_thresholds();
			end
			for (int n = 0; n < SCANS_PER_PHASE; n++)
				send_scan(pick_sample(), pick_sample(), pick_sample(), pick_sample());
			in_valid <= 1'b0;
			drain();
		end

		$display("Checked %0d alarm items over %0d threshold settings", checked, PHASES);
		$display("Alarm levels reached (emergency..normal): %b", level_hits);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS multi_sensor_alarm_zone_tone_select_top");
		end else begin
			$display("FAIL multi_sensor_alarm_zone_tone_select_top");
		end
		$finish;
	end

endmodule
